@@ hw/rtl/ipv4sn_pkg.sv @@
// Shared constants and types for the dotted-decimal IPv4 parser.
package ipv4sn_pkg;

	// Result status codes.
	localparam logic [2:0] ERR_NONE   = 3'd0;
	localparam logic [2:0] ERR_CHAR   = 3'd1;
	localparam logic [2:0] ERR_DIGITS = 3'd2;
	localparam logic [2:0] ERR_RANGE  = 3'd3;
	localparam logic [2:0] ERR_EMPTY  = 3'd4;
	localparam logic [2:0] ERR_DOTS   = 3'd5;
	localparam logic [2:0] ERR_MASK   = 3'd6;

	// ASCII characters of interest.
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_DOT  = 8'h2E;

	// Octet limits.
	localparam logic [9:0] OCTET_MAX  = 10'd255;
	localparam logic [1:0] DIGITS_MAX = 2'd3;
	localparam logic [1:0] DOTS_FULL  = 2'd3;

	// Parse state of the string in progress.
	typedef struct packed {
		logic [9:0]  octet_value;
		logic [1:0]  digit_count;
		logic [1:0]  dot_count;
		logic [31:0] packed_value;
		logic [2:0]  first_error;
	} parse_state_t;

endpackage

@@ hw/rtl/ipv4sn_parse.sv @@
// Character-level parse state: digit accumulation, dot handling and first error.
module ipv4sn_parse
	import ipv4sn_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   character,
	input  logic         last,
	output parse_state_t post
);

	parse_state_t state_q;
	logic         is_digit;
	logic [3:0]   digit;
	logic [9:0]   octet_times_ten;

	assign is_digit = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
	assign digit = 4'(character - CHAR_ZERO);
	assign octet_times_ten = {state_q.octet_value[6:0], 3'b000}
		+ {state_q.octet_value[8:0], 1'b0} + {6'd0, digit};

	// Apply one character to the state, unless an error was already seen.
	always_comb begin
		post = state_q;
		if (state_q.first_error == ERR_NONE) begin
			if (is_digit) begin
				if (state_q.digit_count == DIGITS_MAX) begin
					post.first_error = ERR_DIGITS;
				end else begin
					post.octet_value = octet_times_ten;
					post.digit_count = state_q.digit_count + 2'd1;
				end
			end else if (character == CHAR_DOT) begin
				if (state_q.digit_count == 2'd0) begin
					post.first_error = ERR_EMPTY;
				end else if (state_q.octet_value > OCTET_MAX) begin
					post.first_error = ERR_RANGE;
				end else if (state_q.dot_count == DOTS_FULL) begin
					post.first_error = ERR_DOTS;
				end else begin
					post.packed_value = {state_q.packed_value[23:0],
						state_q.octet_value[7:0]};
					post.dot_count = state_q.dot_count + 2'd1;
					post.octet_value = 10'd0;
					post.digit_count = 2'd0;
				end
			end else begin
				post.first_error = ERR_CHAR;
			end
		end
	end

	// The state clears after the final character of each string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step) begin
			state_q <= last ? '0 : post;
		end
	end

endmodule

@@ hw/rtl/ipv4sn_finish.sv @@
// End-of-string checks, stored address, subnet arithmetic and result register.
module ipv4sn_finish
	import ipv4sn_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         finish,
	input  logic         pop,
	input  logic         is_mask,
	input  parse_state_t post,
	output logic         out_valid,
	output logic         was_mask,
	output logic         ok,
	output logic [2:0]   error_code,
	output logic [31:0]  parsed_value,
	output logic         derived_valid,
	output logic [31:0]  network,
	output logic [31:0]  host_part,
	output logic [31:0]  broadcast
);

	logic [31:0] stored_address_q;
	logic        address_good_q;
	logic [2:0]  shape_err;
	logic [2:0]  err;
	logic [31:0] raw_value;
	logic [31:0] inv;
	logic        good;
	logic        dv;

	// Final octet and dot count checks, in priority order.
	always_comb begin
		if (post.first_error != ERR_NONE) begin
			shape_err = post.first_error;
		end else if (post.digit_count == 2'd0) begin
			shape_err = ERR_EMPTY;
		end else if (post.octet_value > OCTET_MAX) begin
			shape_err = ERR_RANGE;
		end else if (post.dot_count != DOTS_FULL) begin
			shape_err = ERR_DOTS;
		end else begin
			shape_err = ERR_NONE;
		end
	end

	// A mask must be ones from the top then zeros.
	assign raw_value = {post.packed_value[23:0], post.octet_value[7:0]};
	assign inv = ~raw_value;
	always_comb begin
		err = shape_err;
		if ((shape_err == ERR_NONE) && is_mask && ((inv & (inv + 32'd1)) != 32'd0)) begin
			err = ERR_MASK;
		end
	end
	assign good = (err == ERR_NONE);
	assign dv = good && is_mask && address_good_q;

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (finish) begin
			out_valid <= 1'b1;
		end else if (pop) begin
			out_valid <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (finish) begin
			was_mask      <= is_mask;
			ok            <= good;
			error_code    <= err;
			parsed_value  <= good ? raw_value : 32'd0;
			derived_valid <= dv;
			network       <= dv ? (stored_address_q & raw_value) : 32'd0;
			host_part     <= dv ? (stored_address_q & inv) : 32'd0;
			broadcast     <= dv ? ((stored_address_q & raw_value) | inv) : 32'd0;
		end
	end

	// The most recent good address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_address_q <= 32'd0;
			address_good_q   <= 1'b0;
		end else if (finish && good && !is_mask) begin
			stored_address_q <= raw_value;
			address_good_q   <= 1'b1;
		end
	end

endmodule

@@ hw/rtl/ipv4_dotted_parse_subnet_top.sv @@
// Top level of the dotted-decimal IPv4 parser with subnet arithmetic.
// The input channel takes one ASCII character per item with is_mask and last;
// an item is taken at an edge where in_valid is high and in_stall is low.
// The output channel gives one result per string, on the item that had last
// set, under out_valid and out_stall with the same rule.
// Each item lands in the input register; when it moves on from there, the
// parse state updates and, for a final character, the result is written to
// the output register. Throughput is one item per cycle while no final
// character is held in the input register under out_stall.
// While a result waits under out_stall, characters that produce no result
// keep flowing; only a final character is held in the input register, with
// in_stall high, until the output register frees.
// Reset clears the parse state, the stored good address and both valid flags.
module ipv4_dotted_parse_subnet_top
	import ipv4sn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  character,
	input  logic        is_mask,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        was_mask,
	output logic        ok,
	output logic [2:0]  error_code,
	output logic [31:0] parsed_value,
	output logic        derived_valid,
	output logic [31:0] network,
	output logic [31:0] host_part,
	output logic [31:0] broadcast
);

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         mask_s1;
	logic         last_s1;
	logic         advance;
	logic         load_s1;
	parse_state_t post;

	// The staged item moves on unless it yields a result with nowhere to go.
	assign advance = valid_s1 && (!last_s1 || !out_valid || !out_stall);
	assign load_s1 = !valid_s1 || advance;
	assign in_stall = !load_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			char_s1 <= character;
			mask_s1 <= is_mask;
			last_s1 <= last;
		end
	end

	ipv4sn_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.character (char_s1),
		.last      (last_s1),
		.post      (post)
	);

	ipv4sn_finish u_finish (
		.clk           (clk),
		.arst_n        (arst_n),
		.finish        (advance && last_s1),
		.pop           (out_valid && !out_stall),
		.is_mask       (mask_s1),
		.post          (post),
		.out_valid     (out_valid),
		.was_mask      (was_mask),
		.ok            (ok),
		.error_code    (error_code),
		.parsed_value  (parsed_value),
		.derived_valid (derived_valid),
		.network       (network),
		.host_part     (host_part),
		.broadcast     (broadcast)
	);

endmodule
